// ===== sv/motor_ramp_direction_drive_macros.svh =====
// ----------------------------------------------------------------------------
// Motor ramp direction drive: assertion macros
// Concurrent check helpers shared by the drive RTL.
// ----------------------------------------------------------------------------
`ifndef MOTOR_RAMP_DIRECTION_DRIVE_MACROS_SVH
`define MOTOR_RAMP_DIRECTION_DRIVE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MRDD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define MRDD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mrdd_pkg.sv =====
// ----------------------------------------------------------------------------
// mrdd_pkg
// Types, constants and the rate splitter for the motor ramp direction drive.
// ----------------------------------------------------------------------------
`default_nettype none

package mrdd_pkg;

    localparam int MOTOR_COUNT = 2;
    localparam int FULL_DUTY   = 1000;
    localparam int STEP        = 1000;     // ramp rates are in thousandths

    localparam int DUTY_W = 10;
    localparam int OUT_W  = 16;
    localparam int MAG_W  = 15;
    localparam int RATE_W = 20;
    localparam int REM_W  = 10;
    localparam int RQ_W   = 11;            // whole units of a 20-bit rate
    localparam int IDX_W  = 2;

    localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(FULL_DUTY);

    // x / STEP == (x * RECIP_MUL) >> RECIP_SHIFT, exact for any RATE_W-bit x
    localparam int RECIP_SHIFT = 30;
    localparam int RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP_MUL =
        RECIP_W'((2**RECIP_SHIFT + STEP - 1) / STEP);

    localparam int MAX_MAG_RESET   = 1000;
    localparam int MIN_MAG_RESET   = 0;
    localparam int RAMP_RATE_RESET = 1000;
    localparam int STOP_RATE_RESET = 1000000;

    typedef enum logic [1:0] {
        OP_DIRECT,
        OP_RAMP,
        OP_FREE_STOP,
        OP_BRAKE_STOP
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_MAX_MAG,
        CFG_MIN_MAG,
        CFG_RAMP_RATE,
        CFG_STOP_RATE
    } t_cfg_index;

    typedef struct packed {
        logic [RQ_W-1:0]  quo;
        logic [REM_W-1:0] rem;
    } t_rate;

    localparam t_rate RAMP_RESET = '{quo: RQ_W'(RAMP_RATE_RESET / STEP),
                                     rem: REM_W'(RAMP_RATE_RESET % STEP)};
    localparam t_rate STOP_RESET = '{quo: RQ_W'(STOP_RATE_RESET / STEP),
                                     rem: REM_W'(STOP_RATE_RESET % STEP)};

    // split a rate into whole units and thousandths
    function automatic t_rate split_rate(input logic [RATE_W-1:0] rate);
        logic [RATE_W+RECIP_W-1:0] prod;
        logic [RQ_W-1:0]           q;
        logic [RATE_W-1:0]         back;
        t_rate                     res;
        prod     = {{RECIP_W{1'b0}}, rate} * {{RATE_W{1'b0}}, RECIP_MUL};
        q        = prod[RECIP_SHIFT +: RQ_W];
        back     = RATE_W'(q) * RATE_W'(STEP);
        res.quo  = q;
        res.rem  = REM_W'(rate - back);
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/motor_ramp_direction_drive.sv =====
// ----------------------------------------------------------------------------
// motor_ramp_direction_drive
// Two-wheel drive command block with slew limiting and H-bridge direction.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready): one command per request, with
// opcode, motor index and signed target. Output channel (o_out_valid /
// i_out_ready): one result per wheel touched; o_last marks the final one.
// Drive commands give one result, stop commands one per wheel, left first.
// A command sits in an input register, is worked out combinationally into the
// output register and appears on the outputs from there. Drive commands
// sustain one per cycle while the receiver does not stall; a stop gives its
// results one wheel at a time through the single shared ramp/clamp datapath.
// When the receiver stalls, the result holds in the output register and one
// more command is still taken into the input register; then o_in_ready drops.
// Config writes (i_cfg_we) take effect at the next edge; rates are split
// into whole units and thousandths as they are written.
// Synchronous reset restores the register defaults, zeroes the stored
// outputs and remainders, and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "motor_ramp_direction_drive_macros.svh"

module motor_ramp_direction_drive
    import mrdd_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,

    input  wire logic                     i_cfg_we,
    input  wire logic [1:0]               i_cfg_index,
    input  wire logic [RATE_W-1:0]        i_cfg_wdata,

    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [1:0]               i_opcode,
    input  wire logic [IDX_W-1:0]         i_motor_index,
    input  wire logic signed [OUT_W-1:0]  i_target,

    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic                          o_wheel,
    output logic [DUTY_W-1:0]             o_chan_a_duty,
    output logic [DUTY_W-1:0]             o_chan_b_duty,
    output logic signed [OUT_W-1:0]       o_applied_output,
    output logic                          o_status,
    output logic                          o_last
);

    // configuration
    logic [MAG_W-1:0] r_max_mag;
    logic [MAG_W-1:0] r_min_mag;
    t_rate            r_ramp;
    t_rate            r_stop;

    // per-wheel state
    logic signed [OUT_W-1:0] r_stored   [2];
    logic [REM_W-1:0]        r_ramp_rem [2];
    logic [REM_W-1:0]        r_stop_rem [2];

    // input register
    logic                    r_in_valid;
    t_opcode                 r_in_op;
    logic [IDX_W-1:0]        r_in_idx;
    logic signed [OUT_W-1:0] r_in_target;
    logic                    r_phase;

    // output register
    logic                    r_out_valid;
    logic                    r_out_wheel;
    logic [DUTY_W-1:0]       r_out_a;
    logic [DUTY_W-1:0]       r_out_b;
    logic signed [OUT_W-1:0] r_out_applied;
    logic                    r_out_status;
    logic                    r_out_last;

    logic out_free, fire, item_done, in_acc;
    logic is_stop, bad_idx, wheel, res_last, use_stop;

    logic signed [OUT_W-1:0]  cur, aim;
    logic [REM_W-1:0]         rem_in;
    t_rate                    rate;
    logic [REM_W:0]           rsum;
    logic                     carry;
    logic [REM_W-1:0]         sr;
    logic [RQ_W-1:0]          sq;
    logic signed [OUT_W:0]    diff;
    logic [OUT_W:0]           adiff;
    logic                     dec;
    logic signed [OUT_W+1:0]  a_val, q_val;
    logic [REM_W-1:0]         n_rem;
    logic signed [OUT_W:0]    ramp_cmd, cmd;
    logic [OUT_W:0]           mag_raw;
    logic [MAG_W-1:0]         mag_hi, mag;
    logic signed [OUT_W-1:0]  n_stored;
    logic                     fwd;
    logic [DUTY_W-1:0]        duty_a, duty_b;

    // handshake
    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && out_free;
    assign item_done  = fire && res_last;
    assign o_in_ready = !r_in_valid || item_done;
    assign in_acc     = i_in_valid && o_in_ready;

    // request decode
    assign is_stop  = (r_in_op == OP_FREE_STOP) || (r_in_op == OP_BRAKE_STOP);
    assign use_stop = (r_in_op == OP_FREE_STOP);
    assign bad_idx  = !is_stop && ({1'b0, r_in_idx} >= (IDX_W+1)'(MOTOR_COUNT));
    assign wheel    = is_stop ? r_phase : r_in_idx[0];
    assign res_last = !is_stop || ({1'b0, r_phase} == 2'(MOTOR_COUNT - 1));

    always_comb begin
        cur    = r_stored[wheel];
        rem_in = use_stop ? r_stop_rem[wheel] : r_ramp_rem[wheel];
        rate   = use_stop ? r_stop : r_ramp;
        aim    = is_stop ? '0 : r_in_target;

        // step = sq units + sr thousandths
        rsum  = {1'b0, rate.rem} + {1'b0, rem_in};
        carry = (rsum >= (REM_W+1)'(STEP));
        sr    = carry ? REM_W'(rsum - (REM_W+1)'(STEP)) : rsum[REM_W-1:0];
        sq    = rate.quo + RQ_W'(carry);

        diff  = (OUT_W+1)'(cur) - (OUT_W+1)'(aim);
        dec   = (diff > 0);
        adiff = (diff < 0) ? $unsigned(-diff) : $unsigned(diff);

        a_val = dec ? (OUT_W+2)'(cur) - $signed({{(OUT_W+2-RQ_W){1'b0}}, sq})
                    : (OUT_W+2)'(cur) + $signed({{(OUT_W+2-RQ_W){1'b0}}, sq});

        // truncating divide of (1000*a -/+ sr) by 1000
        q_val = a_val;
        n_rem = sr;
        if (sr != '0) begin
            if (dec && (a_val > 0)) begin
                q_val = a_val - (OUT_W+2)'(1);
                n_rem = REM_W'(STEP) - sr;
            end else if (!dec && (a_val < 0)) begin
                q_val = a_val + (OUT_W+2)'(1);
                n_rem = REM_W'(STEP) - sr;
            end
        end

        // the step lands short of the aim only when |d| exceeds whole units
        ramp_cmd = (adiff > (OUT_W+1)'(sq)) ? (OUT_W+1)'(q_val) : (OUT_W+1)'(aim);

        unique case (r_in_op) inside
            OP_DIRECT:              cmd = (OUT_W+1)'(r_in_target);
            OP_RAMP, OP_FREE_STOP:  cmd = ramp_cmd;
            default:                cmd = '0;
        endcase

        // clamp; min wins over max
        mag_raw  = (cmd < 0) ? $unsigned(-cmd) : $unsigned(cmd);
        mag_hi   = (mag_raw > (OUT_W+1)'(r_max_mag)) ? r_max_mag : mag_raw[MAG_W-1:0];
        mag      = (mag_hi < r_min_mag) ? r_min_mag : mag_hi;
        n_stored = (cmd > 0) ? $signed(OUT_W'(mag)) : -$signed(OUT_W'(mag));

        // right wheel is mirrored
        fwd    = (cmd > 0) != wheel;
        duty_a = ((cmd != 0) && fwd)  ? DUTY_FULL : '0;
        duty_b = ((cmd != 0) && !fwd) ? DUTY_FULL : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_mag   <= MAG_W'(MAX_MAG_RESET);
            r_min_mag   <= MAG_W'(MIN_MAG_RESET);
            r_ramp      <= RAMP_RESET;
            r_stop      <= STOP_RESET;
            for (int i = 0; i < 2; i++) begin
                r_stored[i]   <= '0;
                r_ramp_rem[i] <= '0;
                r_stop_rem[i] <= '0;
            end
            r_in_valid  <= 1'b0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_MAX_MAG:   r_max_mag <= i_cfg_wdata[MAG_W-1:0];
                    CFG_MIN_MAG:   r_min_mag <= i_cfg_wdata[MAG_W-1:0];
                    CFG_RAMP_RATE: r_ramp    <= split_rate(i_cfg_wdata);
                    CFG_STOP_RATE: r_stop    <= split_rate(i_cfg_wdata);
                    default: ;
                endcase
            end

            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (item_done) begin
                r_in_valid <= 1'b0;
            end

            if (fire) begin
                r_phase <= res_last ? 1'b0 : !r_phase;
                if (!bad_idx) begin
                    r_stored[wheel] <= n_stored;
                    if (r_in_op == OP_RAMP) begin
                        r_ramp_rem[wheel] <= n_rem;
                    end
                    if (r_in_op == OP_FREE_STOP) begin
                        r_stop_rem[wheel] <= n_rem;
                    end
                end
            end

            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_op     <= t_opcode'(i_opcode);
            r_in_idx    <= i_motor_index;
            r_in_target <= i_target;
        end
        if (fire) begin
            if (bad_idx) begin
                r_out_wheel   <= 1'b0;
                r_out_a       <= '0;
                r_out_b       <= '0;
                r_out_applied <= '0;
                r_out_status  <= 1'b1;
                r_out_last    <= 1'b1;
            end else begin
                r_out_wheel   <= wheel;
                r_out_a       <= duty_a;
                r_out_b       <= duty_b;
                r_out_applied <= n_stored;
                r_out_status  <= 1'b0;
                r_out_last    <= res_last;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_wheel          = r_out_wheel;
    assign o_chan_a_duty    = r_out_a;
    assign o_chan_b_duty    = r_out_b;
    assign o_applied_output = r_out_applied;
    assign o_status         = r_out_status;
    assign o_last           = r_out_last;

    `MRDD_ASSERT_SAME(a_err_fields_zero, i_clk, i_rst_n,
        r_out_valid && r_out_status,
        r_out_last && (r_out_applied == '0) && (r_out_a == '0) && (r_out_b == '0),
        "error result carries nonzero fields")
    `MRDD_ASSERT_SAME(a_bridge_exclusive, i_clk, i_rst_n,
        r_out_valid,
        (r_out_a == '0) || (r_out_b == '0),
        "both bridge channels driven")
    `MRDD_ASSERT_SAME(a_first_of_stop, i_clk, i_rst_n,
        r_out_valid && !r_out_last,
        !r_out_wheel && !r_out_status,
        "non-final result not on left wheel")
    `MRDD_ASSERT_NEXT(a_stop_blocks_input, i_clk, i_rst_n,
        in_acc && ((i_opcode == OP_FREE_STOP) || (i_opcode == OP_BRAKE_STOP)),
        !o_in_ready,
        "stop request did not hold off the next request")

endmodule

`default_nettype wire
